@@ rtl/v3au_pkg.sv @@
// shared opcode and status codes of the three-component vector unit
package v3au_pkg;

  typedef enum logic [3:0] {
    OP_ADDV  = 4'd0,
    OP_ADDS  = 4'd1,
    OP_SUBV  = 4'd2,
    OP_SUBS  = 4'd3,
    OP_MULV  = 4'd4,
    OP_MULS  = 4'd5,
    OP_DIVV  = 4'd6,
    OP_DIVS  = 4'd7,
    OP_ABS   = 4'd8,
    OP_DOT   = 4'd9,
    OP_CROSS = 4'd10,
    OP_LEN   = 4'd11,
    OP_NORM  = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  // division by zero outranks overflow
  function automatic status_e st_max(input status_e cur, input status_e nxt);
    return (nxt > cur) ? nxt : cur;
  endfunction

endpackage

@@ rtl/v3au_front.sv @@
// front end: operand select, add/sub/abs, multipliers and product combine
module v3au_front #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [3:0]                    kind_i,
  input  logic signed [WORD_BITS-1:0]   a_i [3],
  input  logic signed [WORD_BITS-1:0]   b_i [3],
  input  logic signed [WORD_BITS-1:0]   scalar_i,
  output logic                          valid_o,
  output v3au_pkg::op_e                 kind_o,
  output v3au_pkg::status_e             st_o,
  output logic [WORD_BITS-1:0]          r_o [3],
  output logic [WORD_BITS-1:0]          rs_o,
  output logic [2*WORD_BITS-1:0]        sumsq_o,
  output logic [WORD_BITS-1:0]          num_o [3],
  output logic [WORD_BITS-1:0]          den_o [3],
  output logic [2:0]                    aneg_o,
  output logic [2:0]                    qneg_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned XW = 2 * WORD_BITS + 2;
  localparam logic [W-1:0] SatMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SatMin = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] Half = {{(XW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // round to nearest (ties up), then saturate; msb flags overflow
  function automatic logic [W:0] rnd_sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    logic                 ovf;
    y   = (x + Half) >>> FRAC_BITS;
    ovf = (y[XW-1:W-1] != {(XW-W+1){y[XW-1]}});
    return ovf ? {1'b1, (y[XW-1] ? SatMin : SatMax)} : {1'b0, y[W-1:0]};
  endfunction

  // stage 1 combinational
  v3au_pkg::op_e       kind;
  logic                is_scal;
  logic signed [W-1:0] opd [3];
  logic signed [W:0]   ext [3];
  logic [W-1:0]        r1 [3];
  v3au_pkg::status_e   st1;
  logic signed [W-1:0] ma [6];
  logic signed [W-1:0] mb [6];
  logic [W-1:0]        num1 [3];
  logic [W-1:0]        den1 [3];
  logic [2:0]          aneg1;
  logic [2:0]          qneg1;

  always_comb begin
    kind    = v3au_pkg::op_e'(kind_i);
    is_scal = (kind_i <= 4'd7) && kind_i[0];
    st1     = v3au_pkg::ST_OK;
    for (int i = 0; i < 3; i++) begin
      opd[i]   = is_scal ? scalar_i : b_i[i];
      aneg1[i] = a_i[i][W-1];
      qneg1[i] = a_i[i][W-1] ^ opd[i][W-1];
      num1[i]  = a_i[i][W-1] ? W'(-a_i[i]) : a_i[i];
      den1[i]  = opd[i][W-1] ? W'(-opd[i]) : opd[i];
      case (kind)
        v3au_pkg::OP_ADDV, v3au_pkg::OP_ADDS: begin
          ext[i] = {a_i[i][W-1], a_i[i]} + {opd[i][W-1], opd[i]};
        end
        v3au_pkg::OP_SUBV, v3au_pkg::OP_SUBS: begin
          ext[i] = {a_i[i][W-1], a_i[i]} - {opd[i][W-1], opd[i]};
        end
        v3au_pkg::OP_ABS: begin
          ext[i] = a_i[i][W-1] ? -{a_i[i][W-1], a_i[i]} : {a_i[i][W-1], a_i[i]};
        end
        default: begin
          ext[i] = '0;
        end
      endcase
      if (ext[i][W] != ext[i][W-1]) begin
        r1[i] = ext[i][W] ? SatMin : SatMax;
        st1   = v3au_pkg::ST_OVF;
      end else begin
        r1[i] = ext[i][W-1:0];
      end
    end
    // multiplier operands
    case (kind)
      v3au_pkg::OP_CROSS: begin
        ma[0] = a_i[1]; mb[0] = b_i[2];
        ma[1] = a_i[2]; mb[1] = b_i[0];
        ma[2] = a_i[0]; mb[2] = b_i[1];
        ma[3] = a_i[2]; mb[3] = b_i[1];
        ma[4] = a_i[0]; mb[4] = b_i[2];
        ma[5] = a_i[1]; mb[5] = b_i[0];
      end
      v3au_pkg::OP_LEN, v3au_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i]   = a_i[i];
          mb[i]   = a_i[i];
          ma[i+3] = '0;
          mb[i+3] = '0;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          ma[i]   = a_i[i];
          mb[i]   = opd[i];
          ma[i+3] = '0;
          mb[i+3] = '0;
        end
      end
    endcase
  end

  // stage registers
  logic                  s1_v_q, s2_v_q, s3_v_q;
  v3au_pkg::op_e         s1_kind_q, s2_kind_q, s3_kind_q;
  v3au_pkg::status_e     s1_st_q, s2_st_q, s3_st_q;
  logic [W-1:0]          s1_r_q [3];
  logic [W-1:0]          s2_r_q [3];
  logic [W-1:0]          s3_r_q [3];
  logic signed [W-1:0]   s1_ma_q [6];
  logic signed [W-1:0]   s1_mb_q [6];
  logic signed [2*W-1:0] s2_p_q [6];
  logic [W-1:0]          s1_num_q [3];
  logic [W-1:0]          s2_num_q [3];
  logic [W-1:0]          s3_num_q [3];
  logic [W-1:0]          s1_den_q [3];
  logic [W-1:0]          s2_den_q [3];
  logic [W-1:0]          s3_den_q [3];
  logic [2:0]            s1_aneg_q, s2_aneg_q, s3_aneg_q;
  logic [2:0]            s1_qneg_q, s2_qneg_q, s3_qneg_q;
  logic [W-1:0]          s3_rs_q;
  logic [2*W-1:0]        s3_sumsq_q;

  // stage 3 combinational
  logic signed [XW-1:0] dotsum;
  logic [W:0]           t3 [3];
  logic [W:0]           tdot;
  logic [W-1:0]         r3 [3];
  logic [W-1:0]         rs3;
  v3au_pkg::status_e    st3;

  always_comb begin
    dotsum = XW'(s2_p_q[0]) + XW'(s2_p_q[1]) + XW'(s2_p_q[2]);
    tdot   = rnd_sat(dotsum);
    st3    = s2_st_q;
    rs3    = '0;
    for (int i = 0; i < 3; i++) begin
      r3[i] = s2_r_q[i];
      t3[i] = '0;
    end
    case (s2_kind_q)
      v3au_pkg::OP_MULV, v3au_pkg::OP_MULS: begin
        for (int i = 0; i < 3; i++) begin
          t3[i] = rnd_sat(XW'(s2_p_q[i]));
          r3[i] = t3[i][W-1:0];
          if (t3[i][W]) st3 = v3au_pkg::st_max(st3, v3au_pkg::ST_OVF);
        end
      end
      v3au_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t3[i] = rnd_sat(XW'(s2_p_q[i]) - XW'(s2_p_q[i+3]));
          r3[i] = t3[i][W-1:0];
          if (t3[i][W]) st3 = v3au_pkg::st_max(st3, v3au_pkg::ST_OVF);
        end
      end
      v3au_pkg::OP_DOT: begin
        rs3 = tdot[W-1:0];
        if (tdot[W]) st3 = v3au_pkg::st_max(st3, v3au_pkg::ST_OVF);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_kind_q <= kind;
      s1_st_q   <= st1;
      s1_aneg_q <= aneg1;
      s1_qneg_q <= qneg1;
      s1_ma_q   <= ma;
      s1_mb_q   <= mb;
      s1_r_q    <= r1;
      s1_num_q  <= num1;
      s1_den_q  <= den1;

      s2_kind_q <= s1_kind_q;
      s2_st_q   <= s1_st_q;
      s2_aneg_q <= s1_aneg_q;
      s2_qneg_q <= s1_qneg_q;
      s2_r_q    <= s1_r_q;
      s2_num_q  <= s1_num_q;
      s2_den_q  <= s1_den_q;
      for (int k = 0; k < 6; k++) begin
        s2_p_q[k] <= s1_ma_q[k] * s1_mb_q[k];
      end

      s3_kind_q  <= s2_kind_q;
      s3_st_q    <= st3;
      s3_aneg_q  <= s2_aneg_q;
      s3_qneg_q  <= s2_qneg_q;
      s3_r_q     <= r3;
      s3_rs_q    <= rs3;
      s3_sumsq_q <= dotsum[2*W-1:0];
      s3_num_q   <= s2_num_q;
      s3_den_q   <= s2_den_q;
    end
  end

  assign valid_o = s3_v_q;
  assign kind_o  = s3_kind_q;
  assign st_o    = s3_st_q;
  assign r_o     = s3_r_q;
  assign rs_o    = s3_rs_q;
  assign sumsq_o = s3_sumsq_q;
  assign num_o   = s3_num_q;
  assign den_o   = s3_den_q;
  assign aneg_o  = s3_aneg_q;
  assign qneg_o  = s3_qneg_q;

endmodule

@@ rtl/v3au_sqrt.sv @@
// pipelined square root, one root bit per stage, rounded to nearest
module v3au_sqrt #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned SIDE_BITS = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [2*WORD_BITS-1:0] rad_i,
  input  logic [SIDE_BITS-1:0]   side_i,
  output logic                   valid_o,
  output logic [WORD_BITS-1:0]   len_o,
  output logic [SIDE_BITS-1:0]   side_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned RW = WORD_BITS + 2;

  logic                 v_q    [W+1];
  logic [RW-1:0]        rem_q  [W];
  logic [W-1:0]         root_q [W];
  logic [2*W-1:0]       rad_q  [W];
  logic [SIDE_BITS-1:0] side_q [W+1];
  logic [W-1:0]         len_q;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic                 v_in;
    logic [RW-1:0]        rem_in;
    logic [W-1:0]         root_in;
    logic [2*W-1:0]       rad_in;
    logic [SIDE_BITS-1:0] side_in;
    logic [RW+1:0]        cur;
    logic [RW+1:0]        trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_in, rad_in[2*W-1 -: 2]};
    assign trial = {{(RW-W){1'b0}}, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? RW'(cur - trial) : RW'(cur);
        root_q[k] <= {root_in[W-2:0], ge};
        rad_q[k]  <= {rad_in[2*W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[W] <= 1'b0;
    end else if (en_i) begin
      v_q[W] <= v_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q     <= root_q[W-1] + W'(rem_q[W-1] > {2'b00, root_q[W-1]});
      side_q[W] <= side_q[W-1];
    end
  end

  assign valid_o = v_q[W];
  assign len_o   = len_q;
  assign side_o  = side_q[W];

endmodule

@@ rtl/v3au_div.sv @@
// three-lane pipelined restoring divider, one quotient bit per stage, rounded
module v3au_div #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_BITS = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [WORD_BITS-1:0]           num_i [3],
  input  logic [WORD_BITS-1:0]           den_i [3],
  input  logic [SIDE_BITS-1:0]           side_i,
  output logic                           valid_o,
  output logic [WORD_BITS+FRAC_BITS:0]   q_o [3],
  output logic [SIDE_BITS-1:0]           side_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NW = WORD_BITS + FRAC_BITS;

  logic                 v_q    [NW+1];
  logic [SIDE_BITS-1:0] side_q [NW+1];
  logic [W-1:0]         rem_q  [3][NW];
  logic [NW-1:0]        quo_q  [3][NW];
  logic [NW-1:0]        n_q    [3][NW];
  logic [W-1:0]         den_q  [3][NW];
  logic [NW:0]          qr_q   [3];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en_i) begin
          v_q[k] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          side_q[k] <= side_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en_i) begin
          v_q[k] <= v_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [W-1:0]  rem_in;
      logic [NW-1:0] quo_in;
      logic [NW-1:0] n_in;
      logic [W-1:0]  den_in;
      logic [W:0]    cur;
      logic          ge;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign quo_in = '0;
        assign n_in   = {num_i[l], {FRAC_BITS{1'b0}}};
        assign den_in = den_i[l];
      end else begin : g_next
        assign rem_in = rem_q[l][k-1];
        assign quo_in = quo_q[l][k-1];
        assign n_in   = n_q[l][k-1];
        assign den_in = den_q[l][k-1];
      end

      assign cur = {rem_in, n_in[NW-1]};
      assign ge  = (cur >= {1'b0, den_in});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][k] <= ge ? W'(cur - {1'b0, den_in}) : cur[W-1:0];
          quo_q[l][k] <= {quo_in[NW-2:0], ge};
          n_q[l][k]   <= {n_in[NW-2:0], 1'b0};
          den_q[l][k] <= den_in;
        end
      end
    end
  end

  // round to nearest, ties away from zero: 2*rem >= den
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[NW] <= 1'b0;
    end else if (en_i) begin
      v_q[NW] <= v_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[NW] <= side_q[NW-1];
      for (int l = 0; l < 3; l++) begin
        qr_q[l] <= {1'b0, quo_q[l][NW-1]} +
                   (NW+1)'({rem_q[l][NW-1], 1'b0} >= {1'b0, den_q[l][NW-1]});
      end
    end
  end

  assign valid_o = v_q[NW];
  assign q_o     = qr_q;
  assign side_o  = side_q[NW];

endmodule

@@ rtl/vector3_arith_unit.sv @@
// three-component signed fixed-point vector unit, top level
// Takes one item per clock unless the pipe is frozen by an output stall, and
// returns one result per item, in order; the default parameters give Q16.16. Every
// item walks the same pipe: three front stages (operand select and add/sub/abs,
// the six multipliers, product rounding and sums), a square-root pipe of
// WORD_BITS+1 stages (one per root bit, then rounding), a three-lane restoring
// divider of WORD_BITS+FRAC_BITS+1 stages (one per quotient bit, then rounding),
// and a final saturate step that feeds the output register. The root and
// quotient pipes set the latency. A stall at the output freezes the whole pipe
// in place, so in_stall_o is high exactly while a result sits in the output
// register and out_stall_i is high; nothing is dropped or repeated. Results
// saturate to the word range with status 1; division by zero (and normalizing
// a zero vector) gives max, min or zero by the sign of the dividend, status 2.
// Opcodes 13 to 15 return all zeros with status 0.
module vector3_arith_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [3:0]                  kind_i,
  input  logic signed [WORD_BITS-1:0] ax_i,
  input  logic signed [WORD_BITS-1:0] ay_i,
  input  logic signed [WORD_BITS-1:0] az_i,
  input  logic signed [WORD_BITS-1:0] bx_i,
  input  logic signed [WORD_BITS-1:0] by_i,
  input  logic signed [WORD_BITS-1:0] bz_i,
  input  logic signed [WORD_BITS-1:0] scalar_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] rx_o,
  output logic signed [WORD_BITS-1:0] ry_o,
  output logic signed [WORD_BITS-1:0] rz_o,
  output logic signed [WORD_BITS-1:0] rs_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NW = WORD_BITS + FRAC_BITS;
  localparam logic [W-1:0] SatMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SatMin = {1'b1, {(W-1){1'b0}}};

  // item fields riding along the square-root pipe
  typedef struct packed {
    v3au_pkg::op_e        kind;
    v3au_pkg::status_e    st;
    logic [2:0][W-1:0]    r;
    logic [W-1:0]         rs;
    logic [2:0][W-1:0]    num;
    logic [2:0][W-1:0]    den;
    logic [2:0]           aneg;
    logic [2:0]           qneg;
  } sq_side_t;

  // item fields riding along the divider pipe
  typedef struct packed {
    v3au_pkg::op_e        kind;
    v3au_pkg::status_e    st;
    logic [2:0][W-1:0]    r;
    logic [W-1:0]         rs;
    logic [2:0]           aneg;
    logic [2:0]           qneg;
    logic [2:0]           dz;
    logic [2:0]           numz;
  } dv_side_t;

  // whole pipe advances unless a finished result is held
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // front end
  logic signed [W-1:0] a_arr [3];
  logic signed [W-1:0] b_arr [3];
  assign a_arr = '{ax_i, ay_i, az_i};
  assign b_arr = '{bx_i, by_i, bz_i};

  logic              fr_v;
  v3au_pkg::op_e     fr_kind;
  v3au_pkg::status_e fr_st;
  logic [W-1:0]      fr_r [3];
  logic [W-1:0]      fr_rs;
  logic [2*W-1:0]    fr_sumsq;
  logic [W-1:0]      fr_num [3];
  logic [W-1:0]      fr_den [3];
  logic [2:0]        fr_aneg;
  logic [2:0]        fr_qneg;

  v3au_front #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .kind_i   (kind_i),
    .a_i      (a_arr),
    .b_i      (b_arr),
    .scalar_i (scalar_i),
    .valid_o  (fr_v),
    .kind_o   (fr_kind),
    .st_o     (fr_st),
    .r_o      (fr_r),
    .rs_o     (fr_rs),
    .sumsq_o  (fr_sumsq),
    .num_o    (fr_num),
    .den_o    (fr_den),
    .aneg_o   (fr_aneg),
    .qneg_o   (fr_qneg)
  );

  sq_side_t sq_in;
  always_comb begin
    sq_in.kind = fr_kind;
    sq_in.st   = fr_st;
    sq_in.rs   = fr_rs;
    sq_in.aneg = fr_aneg;
    sq_in.qneg = fr_qneg;
    for (int i = 0; i < 3; i++) begin
      sq_in.r[i]   = fr_r[i];
      sq_in.num[i] = fr_num[i];
      sq_in.den[i] = fr_den[i];
    end
  end

  // square root of the sum of squares
  logic         sq_v;
  logic [W-1:0] sq_len;
  sq_side_t     sq_out;

  v3au_sqrt #(
    .WORD_BITS(WORD_BITS),
    .SIDE_BITS($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .rad_i   (fr_sumsq),
    .side_i  (sq_in),
    .valid_o (sq_v),
    .len_o   (sq_len),
    .side_o  (sq_out)
  );

  // normalize divides by the length, the divide ops by |B| or |scalar|
  dv_side_t     dv_in;
  logic [W-1:0] dv_num [3];
  logic [W-1:0] dv_den [3];
  logic         is_norm;

  always_comb begin
    is_norm     = (sq_out.kind == v3au_pkg::OP_NORM);
    dv_in.kind  = sq_out.kind;
    dv_in.st    = sq_out.st;
    dv_in.r     = sq_out.r;
    dv_in.rs    = sq_out.rs;
    dv_in.aneg  = sq_out.aneg;
    for (int i = 0; i < 3; i++) begin
      dv_num[i]     = sq_out.num[i];
      dv_den[i]     = is_norm ? sq_len : sq_out.den[i];
      dv_in.qneg[i] = is_norm ? sq_out.aneg[i] : sq_out.qneg[i];
      dv_in.dz[i]   = (dv_den[i] == '0);
      dv_in.numz[i] = (sq_out.num[i] == '0);
    end
    // length is unsigned; above the signed range it saturates
    if (sq_out.kind == v3au_pkg::OP_LEN) begin
      dv_in.rs = sq_len[W-1] ? SatMax : sq_len;
      if (sq_len[W-1]) dv_in.st = v3au_pkg::st_max(sq_out.st, v3au_pkg::ST_OVF);
    end
  end

  // divider lanes
  logic         dv_v;
  logic [NW:0]  dv_q [3];
  dv_side_t     dv_out;

  v3au_div #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_BITS($bits(dv_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .side_i  (dv_in),
    .valid_o (dv_v),
    .q_o     (dv_q),
    .side_o  (dv_out)
  );

  // sign and saturate the quotients
  logic [W-1:0]      fin_r [3];
  logic [W-1:0]      fin_rs;
  v3au_pkg::status_e fin_st;
  logic              is_div;

  always_comb begin
    is_div = (dv_out.kind == v3au_pkg::OP_DIVV) || (dv_out.kind == v3au_pkg::OP_DIVS) ||
             (dv_out.kind == v3au_pkg::OP_NORM);
    fin_rs = dv_out.rs;
    fin_st = dv_out.st;
    for (int i = 0; i < 3; i++) begin
      fin_r[i] = dv_out.r[i];
      if (is_div) begin
        if (dv_out.dz[i]) begin
          fin_st   = v3au_pkg::st_max(fin_st, v3au_pkg::ST_DZ);
          fin_r[i] = dv_out.numz[i] ? '0 : (dv_out.aneg[i] ? SatMin : SatMax);
        end else if (dv_out.qneg[i]) begin
          if (dv_q[i] > (NW+1)'(SatMin)) begin
            fin_st   = v3au_pkg::st_max(fin_st, v3au_pkg::ST_OVF);
            fin_r[i] = SatMin;
          end else begin
            fin_r[i] = -dv_q[i][W-1:0];
          end
        end else begin
          if (dv_q[i] > (NW+1)'(SatMax)) begin
            fin_st   = v3au_pkg::st_max(fin_st, v3au_pkg::ST_OVF);
            fin_r[i] = SatMax;
          end else begin
            fin_r[i] = dv_q[i][W-1:0];
          end
        end
      end
    end
  end

  // output register
  logic              out_v_q;
  logic [W-1:0]      rx_q, ry_q, rz_q, rs_q;
  v3au_pkg::status_e status_q;
  v3au_pkg::op_e     out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q       <= fin_r[0];
      ry_q       <= fin_r[1];
      rz_q       <= fin_r[2];
      rs_q       <= fin_rs;
      status_q   <= fin_st;
      out_kind_q <= dv_out.kind;
    end
  end

  assign out_valid_o = out_v_q;
  assign rx_o        = rx_q;
  assign ry_o        = ry_q;
  assign rz_o        = rz_q;
  assign rs_o        = rs_q;
  assign status_o    = status_q;

  // scalar ops leave the vector fields clear
  a_scalar_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_q == v3au_pkg::OP_DOT || out_kind_q == v3au_pkg::OP_LEN)
    |-> rx_o == '0 && ry_o == '0 && rz_o == '0)
    else $error("vector fields set on a scalar result");

  // vector ops leave the scalar field clear
  a_vec_scalar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_q != v3au_pkg::OP_DOT && out_kind_q != v3au_pkg::OP_LEN
    |-> rs_o == '0)
    else $error("scalar field set on a vector result");

  // only dividing ops can report division by zero
  a_dz_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == v3au_pkg::ST_DZ
    |-> out_kind_q == v3au_pkg::OP_DIVV || out_kind_q == v3au_pkg::OP_DIVS ||
        out_kind_q == v3au_pkg::OP_NORM)
    else $error("division by zero reported on a non-dividing op");

  // unused opcodes give a clean zero result
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_q > v3au_pkg::OP_NORM
    |-> status_o == v3au_pkg::ST_OK && rx_o == '0 && ry_o == '0 && rz_o == '0 &&
        rs_o == '0)
    else $error("unused opcode gave a nonzero result");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the three-component fixed-point vector unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LATENCY = 2 * W + F + 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic signed [W-1:0] WMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] WMIN = 32'sh80000000;

  typedef struct packed {
    logic [3:0]          kind;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, scalar;
  } vec_item_t;

  typedef struct packed {
    logic signed [W-1:0] rx, ry, rz, rs;
    logic [1:0]          status;
  } vec_result_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [3:0] kind_i;
  logic signed [W-1:0] ax_i, ay_i, az_i, bx_i, by_i, bz_i, scalar_i;
  logic signed [W-1:0] rx_o, ry_o, rz_o, rs_o;
  logic [1:0] status_o;

  vector3_arith_unit #(.WORD_BITS(W), .FRAC_BITS(F)) dut (.*);

  vec_result_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit stimulus_done = 0;
  bit quiet_phase = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // predictor, wide signed math so no intermediate can wrap
  // ---------------------------------------------------------------
  function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v,
                                                 inout v3au_pkg::status_e st);
    if (v > 128'sd2147483647) begin
      st = v3au_pkg::st_max(st, v3au_pkg::ST_OVF);
      return WMAX;
    end
    if (v < -128'sd2147483648) begin
      st = v3au_pkg::st_max(st, v3au_pkg::ST_OVF);
      return WMIN;
    end
    return v[W-1:0];
  endfunction

  // product rounding: add half then floor shift
  function automatic logic signed [127:0] round_q(input logic signed [127:0] p);
    return (p + (128'sd1 <<< (F - 1))) >>> F;
  endfunction

  function automatic logic signed [W-1:0] fx_div(input logic signed [127:0] a,
                                                  input logic signed [127:0] b,
                                                  inout v3au_pkg::status_e st);
    logic [127:0] n, d, q, r;
    logic signed [127:0] sq;
    if (b == 0) begin
      st = v3au_pkg::st_max(st, v3au_pkg::ST_DZ);
      return (a == 0) ? '0 : (a < 0 ? WMIN : WMAX);
    end
    n = (a < 0 ? -a : a) << F;
    d = b < 0 ? -b : b;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;   // nearest, ties away from zero
    sq = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
    return clamp(sq, st);
  endfunction

  function automatic logic [127:0] round_sqrt(input logic [127:0] s);
    logic [127:0] r, c;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= s) r = c;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic vec_result_t vector_alu(input vec_item_t it);
    vec_result_t res;
    v3au_pkg::status_e st;
    logic signed [127:0] a[3], b[3], o, s, len;
    logic signed [W-1:0] r[3];
    st = v3au_pkg::ST_OK;
    a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
    b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
    s = it.scalar;
    r = '{default: '0};
    res = '0;
    // length of A, used by len and norm
    len = $signed(round_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
    for (int i = 0; i < 3; i++) begin
      // odd kinds up to divs take the scalar as second operand
      o = (it.kind <= v3au_pkg::OP_DIVS && it.kind[0]) ? s : b[i];
      case (it.kind)
        v3au_pkg::OP_ADDV, v3au_pkg::OP_ADDS: r[i] = clamp(a[i] + o, st);
        v3au_pkg::OP_SUBV, v3au_pkg::OP_SUBS: r[i] = clamp(a[i] - o, st);
        v3au_pkg::OP_MULV, v3au_pkg::OP_MULS: r[i] = clamp(round_q(a[i] * o), st);
        v3au_pkg::OP_DIVV, v3au_pkg::OP_DIVS: r[i] = fx_div(a[i], o, st);
        v3au_pkg::OP_ABS:  r[i] = clamp(a[i] < 0 ? -a[i] : a[i], st);
        v3au_pkg::OP_NORM: r[i] = fx_div(a[i], len, st);
        default: ;
      endcase
    end
    if (it.kind == v3au_pkg::OP_CROSS) begin
      r[0] = clamp(round_q(a[1] * b[2] - a[2] * b[1]), st);
      r[1] = clamp(round_q(a[2] * b[0] - a[0] * b[2]), st);
      r[2] = clamp(round_q(a[0] * b[1] - a[1] * b[0]), st);
    end
    if (it.kind == v3au_pkg::OP_DOT)
      res.rs = clamp(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), st);
    if (it.kind == v3au_pkg::OP_LEN)
      res.rs = clamp(len, st);
    res.rx = r[0];
    res.ry = r[1];
    res.rz = r[2];
    res.status = st;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // driver: one item at a time, held until accepted
  // ---------------------------------------------------------------
  function automatic logic signed [W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      4: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      default: return $urandom();
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    vec_item_t it;
    it.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                          : 4'($urandom_range(0, 12));
    it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
    it.bx = rand_word(); it.by = rand_word(); it.bz = rand_word();
    it.scalar = rand_word();
    // sometimes zero divisors on purpose
    if ($urandom_range(0, 9) == 0) begin
      it.bx = '0;
      it.scalar = '0;
    end
    if (it.kind == v3au_pkg::OP_NORM && $urandom_range(0, 9) == 0) begin
      it.ax = '0; it.ay = '0; it.az = '0;
    end
    return it;
  endfunction

  // idles at random except in the quiet phase
  function automatic bit want_idle();
    return !quiet_phase && ($urandom_range(0, 99) < 36);
  endfunction

  task automatic send_item(input vec_item_t it, input bit has_fixed,
                           input vec_result_t fixed);
    while (want_idle()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    ax_i <= it.ax; ay_i <= it.ay; az_i <= it.az;
    bx_i <= it.bx; by_i <= it.by; bz_i <= it.bz;
    scalar_i <= it.scalar;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge
    expected_q.push_back(has_fixed ? fixed : vector_alu(it));
  endtask

  // directed rows: item, whether a result is typed in, and that result
  typedef struct packed {
    vec_item_t   it;
    bit          has_fixed;
    vec_result_t fixed;
  } directed_row_t;

  function automatic vec_item_t mk(input logic [3:0] k,
                                   input logic signed [W-1:0] ax, ay, az,
                                   input logic signed [W-1:0] bx, by, bz, sc);
    vec_item_t it;
    it.kind = k; it.ax = ax; it.ay = ay; it.az = az;
    it.bx = bx; it.by = by; it.bz = bz; it.scalar = sc;
    return it;
  endfunction

  function automatic vec_result_t rv(input logic signed [W-1:0] x, y, z, s,
                                     input v3au_pkg::status_e st);
    vec_result_t r;
    r.rx = x; r.ry = y; r.rz = z; r.rs = s; r.status = st;
    return r;
  endfunction

  localparam logic signed [W-1:0] ONE = 32'sh00010000;
  localparam logic signed [W-1:0] TWO = 32'sh00020000;

  directed_row_t directed_table[] = '{
    // overflow in add saturates high and low
    '{mk(v3au_pkg::OP_ADDV, WMAX, 1, WMIN, 1, 0, -1, 0), 1,
      rv(WMAX, 1, WMIN, 0, v3au_pkg::ST_OVF)},
    '{mk(v3au_pkg::OP_ADDS, ONE, TWO, -ONE, 0, 0, 0, ONE), 1,
      rv(TWO, 32'sh00030000, 0, 0, v3au_pkg::ST_OK)},
    '{mk(v3au_pkg::OP_SUBV, WMIN, 0, 5, 1, WMIN, 5, 0), 1,
      rv(WMIN, WMAX, 0, 0, v3au_pkg::ST_OVF)},
    '{mk(v3au_pkg::OP_SUBS, WMAX, WMIN, 0, 0, 0, 0, -1), 0, '0},
    '{mk(v3au_pkg::OP_MULV, TWO, -TWO, WMAX, TWO, TWO, WMAX, 0), 0, '0},
    '{mk(v3au_pkg::OP_MULS, 1, -1, 32'sh8000, 0, 0, 0, 32'sh8000), 0, '0},
    // division by zero: max, min, zero by sign of dividend
    '{mk(v3au_pkg::OP_DIVV, 5, -5, 0, 0, 0, 0, 0), 1,
      rv(WMAX, WMIN, 0, 0, v3au_pkg::ST_DZ)},
    '{mk(v3au_pkg::OP_DIVS, ONE, -ONE, TWO, 0, 0, 0, TWO), 1,
      rv(32'sh8000, -32'sh8000, ONE, 0, v3au_pkg::ST_OK)},
    '{mk(v3au_pkg::OP_DIVV, WMAX, WMIN, 1, 1, 1, 3, 0), 0, '0},
    // abs of the minimum saturates
    '{mk(v3au_pkg::OP_ABS, WMIN, -ONE, WMAX, 0, 0, 0, 0), 1,
      rv(WMAX, ONE, WMAX, 0, v3au_pkg::ST_OVF)},
    '{mk(v3au_pkg::OP_DOT, ONE, TWO, 0, TWO, ONE, WMAX, 0), 1,
      rv(0, 0, 0, 32'sh00040000, v3au_pkg::ST_OK)},
    '{mk(v3au_pkg::OP_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0), 0, '0},
    '{mk(v3au_pkg::OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 1,
      rv(0, 0, ONE, 0, v3au_pkg::ST_OK)},
    '{mk(v3au_pkg::OP_CROSS, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, 0), 0, '0},
    '{mk(v3au_pkg::OP_LEN, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0), 1,
      rv(0, 0, 0, 32'sh00050000, v3au_pkg::ST_OK)},
    '{mk(v3au_pkg::OP_LEN, WMIN, WMIN, WMIN, 0, 0, 0, 0), 0, '0},
    // normalize of zero vector: 0/0 everywhere
    '{mk(v3au_pkg::OP_NORM, 0, 0, 0, 1, 1, 1, 1), 1,
      rv(0, 0, 0, 0, v3au_pkg::ST_DZ)},
    '{mk(v3au_pkg::OP_NORM, 0, 32'sh00050000, 0, 0, 0, 0, 0), 1,
      rv(0, ONE, 0, 0, v3au_pkg::ST_OK)},
    '{mk(v3au_pkg::OP_NORM, 1, WMIN, -1, 0, 0, 0, 0), 0, '0},
    // unused opcodes give zeros
    '{mk(4'd13, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX), 1,
      rv(0, 0, 0, 0, v3au_pkg::ST_OK)},
    '{mk(4'd15, -1, -1, -1, -1, -1, -1, -1), 1, rv(0, 0, 0, 0, v3au_pkg::ST_OK)}
  };

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = '0;
    ax_i = '0; ay_i = '0; az_i = '0;
    bx_i = '0; by_i = '0; bz_i = '0; scalar_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_table[i])
      send_item(directed_table[i].it, directed_table[i].has_fixed,
                directed_table[i].fixed);
    for (int n = 0; n < 900; n++) begin
      // a long stretch with no idling on either side
      quiet_phase = (n >= 300 && n < 450);
      send_item(rand_item(), 0, '0);
    end
    quiet_phase = 0;
    in_valid_i <= 1'b0;
    stimulus_done = 1;
  end

  // ---------------------------------------------------------------
  // receiver side stall and result checking
  // ---------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= want_idle();
    end
  end

  always @(posedge clk_i) begin
    vec_result_t got, exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{rx_o, ry_o, rz_o, rs_o, status_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rx %h/%h ry %h/%h rz %h/%h rs %h/%h st %0d/%0d",
                     exp_r.rx, got.rx, exp_r.ry, got.ry, exp_r.rz, got.rz,
                     exp_r.rs, got.rs, exp_r.status, got.status);
        end
      end
    end
  end

  // watchdog: cycles in which no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_ni);
    while (!(stimulus_done && expected_q.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      // let stray results surface
      repeat (LATENCY * 2) @(posedge clk_i);
      if (mismatches == 0 && expected_q.size() == 0)
        $display("[ OK ] regression clean");
      else
        $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
